@@ src/mis_pkg.sv @@
package mis_pkg;

    // Default vertex count; the store holds at most 2^16 entries (16-bit ids)
    localparam int DEF_NUM_VERTICES = 65536;
    localparam int VERTEX_ID_W      = 16;
    localparam int MAX_STORE_DEPTH  = 65536;

    // Vertex status codes
    localparam logic [1:0] ST_UNDECIDED = 2'd0;
    localparam logic [1:0] ST_SEMI_IN   = 2'd1;
    localparam logic [1:0] ST_OUT       = 2'd2;
    localparam logic [1:0] ST_IN        = 2'd3;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [31:0] DEGREE_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_EDGE   = 2'd1,
        OP_COMMIT = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] head_vertex;
        logic [15:0] tail_vertex;
        logic [15:0] degree;
        logic        end_of_pass;
    } item_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        still_active;
        logic [16:0] frontier_count;
        logic [31:0] degree_sum;
        logic        pass_done;
    } result_word_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic exec;
    } mis_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } mis_status_t;

endpackage

@@ src/mis_ctrl.sv @@
module mis_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  mis_pkg::mis_status_t dp_status,
    output mis_pkg::mis_cmd_t    cmd
);
    import mis_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (dp_status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (dp_status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Drive commands
    always_comb
    begin
        cmd.clear_en = 1'b0;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        item_stall   = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            S_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            S_EXEC:
            begin
                cmd.exec = dp_status.out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ src/mis_datapath.sv @@
module mis_datapath #(
    parameter int NUM_VERTICES = mis_pkg::DEF_NUM_VERTICES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mis_pkg::item_word_t   item,
    input  mis_pkg::mis_cmd_t     cmd,
    output mis_pkg::mis_status_t  dp_status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mis_pkg::result_word_t result
);
    import mis_pkg::*;

    localparam int DEPTH = (NUM_VERTICES > MAX_STORE_DEPTH) ? MAX_STORE_DEPTH : NUM_VERTICES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [16:0] VERT_LIMIT = 17'(DEPTH);

    // Entry layout: {active, status}
    logic [2:0] vertex_mem [DEPTH];

    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [2:0]         head_rd_reg;
    logic [2:0]         tail_rd_reg;
    item_word_t         word_reg;
    logic [16:0]        kept_count_reg;
    logic [16:0]        kept_count_next;
    logic [31:0]        kept_degree_reg;
    logic [31:0]        kept_degree_next;
    result_word_t       result_reg;
    result_word_t       result_next;
    logic               result_valid_reg;

    logic               head_in;
    logic               tail_in;
    logic [1:0]         hs;
    logic               ha;
    logic               keep;
    logic [16:0]        count_new;
    logic [32:0]        degree_wide;
    logic [31:0]        degree_new;

    // Clear pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign dp_status.clear_last = cmd.clear_en && (clr_addr_reg == LAST_ADDR);
    assign dp_status.out_free   = !result_valid_reg || !result_stall;

    // Write the vertex store: clear pass or state update
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            vertex_mem[clr_addr_reg] <= {1'b1, ST_SEMI_IN};
        end
        else if (cmd.exec && head_in)
        begin
            vertex_mem[word_reg.head_vertex[ADDR_W-1:0]] <= {ha, hs};
        end
    end

    // Capture the word and read head and tail entries
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_reg    <= item;
            head_rd_reg <= vertex_mem[item.head_vertex[ADDR_W-1:0]];
            tail_rd_reg <= vertex_mem[item.tail_vertex[ADDR_W-1:0]];
        end
    end

    assign head_in = {1'b0, word_reg.head_vertex} < VERT_LIMIT;
    assign tail_in = {1'b0, word_reg.tail_vertex} < VERT_LIMIT;

    // Apply the operation to the head entry
    always_comb
    begin
        hs   = head_rd_reg[1:0];
        ha   = head_rd_reg[2];
        keep = 1'b0;
        case (word_reg.operation)
            OP_INIT:
            begin
                hs = ST_SEMI_IN;
                ha = 1'b1;
            end
            OP_EDGE:
            begin
                if (ha && tail_in)
                begin
                    if (tail_rd_reg[1:0] == ST_IN)
                    begin
                        hs = ST_OUT;
                    end
                    else if ((word_reg.tail_vertex < word_reg.head_vertex)
                             && (tail_rd_reg[1:0] != ST_OUT)
                             && (hs == ST_SEMI_IN))
                    begin
                        hs = ST_UNDECIDED;
                    end
                end
            end
            OP_COMMIT:
            begin
                if (ha)
                begin
                    if (hs == ST_SEMI_IN)
                    begin
                        hs = ST_IN;
                        ha = 1'b0;
                    end
                    else if (hs == ST_OUT)
                    begin
                        ha = 1'b0;
                    end
                    else
                    begin
                        hs   = ST_SEMI_IN;
                        keep = head_in;
                    end
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Saturating pass totals
    always_comb
    begin
        count_new   = kept_count_reg;
        degree_wide = {1'b0, kept_degree_reg} + {17'd0, word_reg.degree};
        degree_new  = kept_degree_reg;
        if (keep)
        begin
            if (kept_count_reg != COUNT_MAX)
            begin
                count_new = kept_count_reg + 17'd1;
            end
            degree_new = degree_wide[32] ? DEGREE_MAX : degree_wide[31:0];
        end
        kept_count_next  = word_reg.end_of_pass ? '0 : count_new;
        kept_degree_next = word_reg.end_of_pass ? '0 : degree_new;

        result_next.status         = head_in ? hs : ST_UNDECIDED;
        result_next.still_active   = head_in && ha;
        result_next.frontier_count = count_new;
        result_next.degree_sum     = degree_new;
        result_next.pass_done      = word_reg.end_of_pass;
    end

    // Hold totals and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg   <= '0;
            kept_degree_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            kept_count_reg   <= kept_count_next;
            kept_degree_reg  <= kept_degree_next;
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ src/maximal_independent_set_engine_top.sv @@
// Flow: an accepted word and its store entries are registered, then the update
// registers its result; no new word is taken until that update is done (store read
// step, then update-and-write step), and a stalled result holds the engine in the
// update cycle until it is taken. Reset: control and totals clear at once; then a
// clearing pass writes every vertex entry to semi-in and active, one per cycle, over
// min(NUM_VERTICES, 65536) entries, with no word accepted meanwhile.
module maximal_independent_set_engine_top #(
    parameter int NUM_VERTICES = mis_pkg::DEF_NUM_VERTICES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  mis_pkg::item_word_t   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mis_pkg::result_word_t result
);
    import mis_pkg::*;

    mis_cmd_t    cmd;
    mis_status_t dp_status;

    mis_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .dp_status  (dp_status),
        .cmd        (cmd)
    );

    mis_datapath #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // One word in flight: the input stalls in the cycle after a word is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("word accepted back to back");

    // An update never overwrites a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !(result_valid && result_stall))
        else $error("waiting result overwritten");

    // An update always presents a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> result_valid)
        else $error("update lost its result");

    // No word is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> (item_stall && !cmd.exec))
        else $error("word taken during clearing pass");

endmodule
